// ===== rtl/core/cfu_pkg.sv =====
// shared types, codes and lookup functions for the can receive filter and unpacker
package cfu_pkg;

	localparam int CFU_QUEUE_DEPTH = 4;
	localparam logic [7:0] COLOR_ENTRIES = 8'd20;
	localparam logic [31:0] COLOR_FALLBACK = 32'h0000_00ff;

	typedef enum logic [1:0] {
		FUNC_REG  = 2'd0,
		FUNC_HDR  = 2'd1,
		FUNC_BYTE = 2'd2
	} cfu_func_t;

	localparam logic KIND_COLOR = 1'b0;
	localparam logic KIND_MSG   = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  new_module;
		logic [28:0] frame_id;
		logic        is_remote;
		logic [3:0]  payload_length;
		logic [7:0]  data_byte;
	} cfu_item_t;

	typedef struct packed {
		logic        kind;
		logic        last_of_run;
		logic [31:0] color;
		logic        event_flag;
		logic [7:0]  source_module;
		logic        linked_flag;
		logic        ack_flag;
		logic [2:0]  feature_class;
		logic [4:0]  feature_index;
		logic [7:0]  function_code;
		logic [3:0]  length_out;
		logic [63:0] payload_value;
	} cfu_result_t;

	// results handed from the unpacker to the output queue in one cycle
	typedef struct packed {
		logic [1:0]  count;
		cfu_result_t first;
		cfu_result_t second;
	} cfu_push_t;

	function automatic logic [7:0] cfu_source(logic [28:0] id);
		return id[25:18];
	endfunction

	function automatic logic [31:0] cfu_colour(logic [7:0] idx);
		logic [31:0] c;
		case (idx)
			8'd0:    c = 32'hb030_6000;
			8'd1:    c = 32'h8a2b_e200;
			8'd2:    c = 32'hffff_5400;
			8'd3:    c = 32'h1e90_ff00;
			8'd4:    c = 32'h00ff_0000;
			8'd5:    c = 32'h8a2b_e200;
			8'd6:    c = 32'h0000_ff00;
			8'd7:    c = 32'hadff_2f00;
			8'd8:    c = 32'hff00_0000;
			8'd9:    c = 32'h00ff_ff00;
			8'd10:   c = 32'hb030_60ff;
			8'd11:   c = 32'h8a2b_e2ff;
			8'd12:   c = 32'hffff_54ff;
			8'd13:   c = 32'h1e90_ffff;
			8'd14:   c = 32'h00ff_00ff;
			8'd15:   c = 32'h8a2b_e2ff;
			8'd16:   c = 32'h0000_ffff;
			8'd17:   c = 32'hadff_2fff;
			8'd18:   c = 32'hff00_00ff;
			8'd19:   c = 32'h00ff_ffff;
			default: c = COLOR_FALLBACK;
		endcase
		return c;
	endfunction

	function automatic cfu_result_t cfu_colour_result(logic [28:0] id, logic last);
		cfu_result_t r;
		r = '0;
		r.kind = KIND_COLOR;
		r.last_of_run = last;
		r.color = cfu_colour(cfu_source(id));
		return r;
	endfunction

	function automatic cfu_result_t cfu_message(logic [28:0] id, logic [3:0] len,
			logic [63:0] payload);
		cfu_result_t r;
		r = '0;
		r.kind = KIND_MSG;
		r.last_of_run = 1'b1;
		r.event_flag = id[26];
		r.source_module = id[25:18];
		r.linked_flag = id[17];
		r.ack_flag = id[16];
		r.feature_class = id[15:13];
		r.feature_index = id[12:8];
		r.function_code = id[7:0];
		r.length_out = len;
		r.payload_value = payload;
		return r;
	endfunction

endpackage

// ===== rtl/core/cfu_filter.sv =====
// acceptance table of module ids with first-empty insert and parallel match
module cfu_filter #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [7:0]          wr_module,
	input  logic [7:0]          query,
	output logic                match
);
	import cfu_pkg::*;

	logic [7:0]            slot_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] empty;
	logic [SLOT_COUNT-1:0] first_empty;
	logic [SLOT_COUNT-1:0] hit;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			empty[i] = (slot_q[i] == 8'd0);
			hit[i] = (slot_q[i] == query);
		end
	end

	// isolate lowest set bit
	assign first_empty = empty & (~empty + {{(SLOT_COUNT-1){1'b0}}, 1'b1});
	assign match = |hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) slot_q[i] <= 8'd0;
		end else if (wr_en) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (first_empty[i]) slot_q[i] <= wr_module;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(first_empty))
		else $error("more than one slot selected for insert");

endmodule

// ===== rtl/core/cfu_unpack.sv =====
// header decode, payload gathering and result generation for one item per cycle in which fire is high
module cfu_unpack #(
	parameter int MAX_PAYLOAD = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  cfu_pkg::cfu_item_t  item,
	input  logic                match,
	output cfu_pkg::cfu_push_t  push
);
	import cfu_pkg::*;

	localparam logic [3:0] MaxLen = 4'(MAX_PAYLOAD);

	logic [28:0] held_q, held_d;
	logic [63:0] accum_q, accum_d;
	logic [3:0]  seen_q, seen_d;
	logic [3:0]  expected_q, expected_d;
	logic        awaiting_q, awaiting_d;
	logic [3:0]  len_sat;
	cfu_push_t   push_d;

	assign len_sat = (item.payload_length > MaxLen) ? MaxLen : item.payload_length;

	always_comb begin
		held_d = held_q;
		accum_d = accum_q;
		seen_d = seen_q;
		expected_d = expected_q;
		awaiting_d = awaiting_q;
		push_d = '0;
		case (cfu_func_t'(item.func))
			FUNC_HDR: begin
				awaiting_d = 1'b0;
				if (!item.is_remote) begin
					push_d.count = 2'd1;
					push_d.first = cfu_colour_result(item.frame_id, 1'b1);
					if (match) begin
						held_d = item.frame_id;
						accum_d = '0;
						seen_d = 4'd0;
						expected_d = len_sat;
						if (len_sat == 4'd0) begin
							push_d.count = 2'd2;
							push_d.first.last_of_run = 1'b0;
							push_d.second = cfu_message(item.frame_id, 4'd0, 64'd0);
						end else begin
							awaiting_d = 1'b1;
						end
					end
				end
			end
			FUNC_BYTE: begin
				if (awaiting_q) begin
					for (int j = 0; j < 8; j++) begin
						if (seen_q[2:0] == 3'(j))
							accum_d[8*j +: 8] = accum_q[8*j +: 8] | item.data_byte;
					end
					seen_d = seen_q + 4'd1;
					if (seen_d >= expected_q) begin
						awaiting_d = 1'b0;
						push_d.count = 2'd1;
						push_d.first = cfu_message(held_q, expected_q, accum_d);
					end
				end
			end
			default: begin
				// register items are handled by the filter, unused selector does nothing
			end
		endcase
	end

	always_comb begin
		push = push_d;
		if (!fire) push.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			accum_q <= '0;
			seen_q <= '0;
			expected_q <= '0;
			awaiting_q <= 1'b0;
		end else if (fire) begin
			held_q <= held_d;
			accum_q <= accum_d;
			seen_q <= seen_d;
			expected_q <= expected_d;
			awaiting_q <= awaiting_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> (seen_q < expected_q) && (expected_q <= MaxLen))
		else $error("payload byte count out of range while gathering");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (push.first.kind == KIND_COLOR)
			&& !push.first.last_of_run && (push.second.kind == KIND_MSG))
		else $error("bad result pair for zero-length frame");

endmodule

// ===== rtl/core/cfu_out_queue.sv =====
// four-entry result queue taking up to two results per cycle
module cfu_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfu_pkg::cfu_push_t   push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cfu_pkg::cfu_result_t head
);
	import cfu_pkg::*;

	localparam int PtrW = $clog2(CFU_QUEUE_DEPTH);
	localparam int CntW = PtrW + 1;

	cfu_result_t       mem_q [CFU_QUEUE_DEPTH];
	logic [PtrW-1:0]   wp_q, rp_q;
	logic [CntW-1:0]   count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign pop = out_valid && out_ready;
	assign head = mem_q[rp_q];
	// room for a full pair, regardless of this cycle's pop
	assign room = (count_q <= CntW'(CFU_QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wp_q] <= push.first;
		if (push.count == 2'd2) mem_q[wp_q + PtrW'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			wp_q <= wp_q + PtrW'(push.count);
			if (pop) rp_q <= rp_q + PtrW'(1);
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CFU_QUEUE_DEPTH))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> (count_q <= CntW'(CFU_QUEUE_DEPTH - 2)))
		else $error("push without room for a pair");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd3) == 1'b0)
		else $error("invalid push count");

endmodule

// ===== rtl/core/can_receive_filter_unpack.sv =====
// top level: input register, acceptance filter, unpacker and result queue
// Takes one item per cycle unless the result queue is short of room. Each item
// is held in an input register, then decoded combinationally against the acceptance table:
// a register item fills the first empty slot, a frame header is matched against all slots
// in parallel and, unless it is remote, yields its colour result, and payload bytes are
// gathered little-endian until the message result is ready. Results go into a four-entry
// queue; an item leaves the input register only while the queue has room for two results,
// so input ready drops only when the result side has stalled with more than two results
// waiting. A matched header with zero length gives its colour and message results back to back.
module can_receive_filter_unpack #(
	parameter int SLOT_COUNT  = 16,
	parameter int MAX_PAYLOAD = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  new_module,
	input  logic [28:0] frame_id,
	input  logic        is_remote,
	input  logic [3:0]  payload_length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic        last_of_run,
	output logic [31:0] color,
	output logic        event_flag,
	output logic [7:0]  source_module,
	output logic        linked_flag,
	output logic        ack_flag,
	output logic [2:0]  feature_class,
	output logic [4:0]  feature_index,
	output logic [7:0]  function_code,
	output logic [3:0]  length_out,
	output logic [63:0] payload_value
);
	import cfu_pkg::*;

	cfu_item_t   item_s1;
	logic        valid_s1;
	logic        fire;
	logic        room;
	logic        match;
	cfu_push_t   push;
	cfu_result_t head;

	assign fire = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func <= func;
			item_s1.new_module <= new_module;
			item_s1.frame_id <= frame_id;
			item_s1.is_remote <= is_remote;
			item_s1.payload_length <= payload_length;
			item_s1.data_byte <= data_byte;
		end
	end

	cfu_filter #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fire && (item_s1.func == FUNC_REG)),
		.wr_module(item_s1.new_module),
		.query    (cfu_source(item_s1.frame_id)),
		.match    (match)
	);

	cfu_unpack #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_unpack (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.match (match),
		.push  (push)
	);

	cfu_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign kind = head.kind;
	assign last_of_run = head.last_of_run;
	assign color = head.color;
	assign event_flag = head.event_flag;
	assign source_module = head.source_module;
	assign linked_flag = head.linked_flag;
	assign ack_flag = head.ack_flag;
	assign feature_class = head.feature_class;
	assign feature_index = head.feature_index;
	assign function_code = head.function_code;
	assign length_out = head.length_out;
	assign payload_value = head.payload_value;

endmodule

// ===== bench/rx_check_pkg.sv =====
// scoreboard for the can receive filter: filter and unpacker prediction plus result checks
package rx_check_pkg;

	import cfu_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int SLOTS = 16;
	localparam int PAYLOAD_MAX = 8;
	localparam int PRINT_CAP = 100;

	class rx_scoreboard;
		logic [7:0]  accept_table [SLOTS];
		logic [31:0] colour_rom [20];
		logic [28:0] held_id;
		logic [63:0] gathered;
		int unsigned bytes_in;
		int unsigned bytes_due;
		bit          collecting;
		cfu_result_t pending_results [$];

		int errors;
		int useful;
		int ignored;
		int n_reg;
		int n_hdr;
		int n_byte;
		int n_colour;
		int n_msg;

		function new();
			colour_rom = '{
				32'hb030_6000, 32'h8a2b_e200, 32'hffff_5400, 32'h1e90_ff00, 32'h00ff_0000,
				32'h8a2b_e200, 32'h0000_ff00, 32'hadff_2f00, 32'hff00_0000, 32'h00ff_ff00,
				32'hb030_60ff, 32'h8a2b_e2ff, 32'hffff_54ff, 32'h1e90_ffff, 32'h00ff_00ff,
				32'h8a2b_e2ff, 32'h0000_ffff, 32'hadff_2fff, 32'hff00_00ff, 32'h00ff_ffff
			};
			foreach (accept_table[i])
				accept_table[i] = '0;
			held_id = '0;
			gathered = '0;
			bytes_in = 0;
			bytes_due = 0;
			collecting = 1'b0;
		endfunction

		function bit accepts(logic [7:0] src);
			foreach (accept_table[i])
				if (accept_table[i] == src)
					return 1'b1;
			return 1'b0;
		endfunction

		function bit table_full();
			foreach (accept_table[i])
				if (accept_table[i] == 8'd0)
					return 1'b0;
			return 1'b1;
		endfunction

		// a source that passes the filter; zero stands for any empty slot
		function logic [7:0] pick_match();
			logic [7:0] cands [$];
			bit has_empty;
			has_empty = 1'b0;
			foreach (accept_table[i]) begin
				if (accept_table[i] != 8'd0)
					cands.push_back(accept_table[i]);
				else
					has_empty = 1'b1;
			end
			if (has_empty)
				cands.push_back(8'd0);
			return cands[$urandom_range(0, cands.size() - 1)];
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function void push_colour(logic [28:0] id, logic last);
			cfu_result_t r;
			logic [7:0] src;
			r = '0;
			src = id[25:18];
			r.kind = KIND_COLOR;
			r.last_of_run = last;
			r.color = (src < 8'd20) ? colour_rom[src] : 32'h0000_00ff;
			pending_results.push_back(r);
		endfunction

		function void push_message();
			cfu_result_t r;
			r = '0;
			r.kind = KIND_MSG;
			r.last_of_run = 1'b1;
			r.event_flag = held_id[26];
			r.source_module = held_id[25:18];
			r.linked_flag = held_id[17];
			r.ack_flag = held_id[16];
			r.feature_class = held_id[15:13];
			r.feature_index = held_id[12:8];
			r.function_code = held_id[7:0];
			r.length_out = bytes_due[3:0];
			r.payload_value = gathered;
			pending_results.push_back(r);
		endfunction

		// one accepted input item: update the filter state and queue what it causes
		function void note_item(cfu_item_t it);
			bit placed;
			int unsigned len;
			placed = 1'b0;
			case (it.func)
				FUNC_REG: begin
					foreach (accept_table[i]) begin
						if (!placed && accept_table[i] == 8'd0) begin
							accept_table[i] = it.new_module;
							placed = 1'b1;
						end
					end
					if (placed && it.new_module != 8'd0) begin
						useful++;
						n_reg++;
					end else begin
						ignored++;
					end
				end
				FUNC_HDR: begin
					useful++;
					n_hdr++;
					collecting = 1'b0;
					if (!it.is_remote) begin
						if (!accepts(it.frame_id[25:18])) begin
							push_colour(it.frame_id, 1'b1);
						end else begin
							len = it.payload_length;
							if (len > PAYLOAD_MAX)
								len = PAYLOAD_MAX;
							held_id = it.frame_id;
							gathered = '0;
							bytes_in = 0;
							bytes_due = len;
							if (len == 0) begin
								push_colour(it.frame_id, 1'b0);
								push_message();
							end else begin
								collecting = 1'b1;
								push_colour(it.frame_id, 1'b1);
							end
						end
					end
				end
				FUNC_BYTE: begin
					if (!collecting || bytes_in >= PAYLOAD_MAX) begin
						ignored++;
					end else begin
						useful++;
						n_byte++;
						gathered = gathered | (64'(it.data_byte) << (8 * bytes_in));
						bytes_in++;
						if (bytes_in >= bytes_due) begin
							collecting = 1'b0;
							push_message();
						end
					end
				end
				default: ignored++;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("tb: mismatch: %s", msg);
		endtask

		task compare_field(int idx, string name, logic [63:0] got, logic [63:0] exp);
			if (got !== exp)
				report($sformatf("result %0d %s: got %0h, expected %0h", idx, name, got, exp));
		endtask

		task check_result(cfu_result_t got);
			cfu_result_t exp;
			int idx;
			idx = n_colour + n_msg;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", idx));
			end else begin
				exp = pending_results.pop_front();
				if (exp.kind == KIND_MSG)
					n_msg++;
				else
					n_colour++;
				compare_field(idx, "kind", 64'(got.kind), 64'(exp.kind));
				compare_field(idx, "last_of_run", 64'(got.last_of_run), 64'(exp.last_of_run));
				compare_field(idx, "color", 64'(got.color), 64'(exp.color));
				compare_field(idx, "event_flag", 64'(got.event_flag), 64'(exp.event_flag));
				compare_field(idx, "source_module", 64'(got.source_module),
					64'(exp.source_module));
				compare_field(idx, "linked_flag", 64'(got.linked_flag), 64'(exp.linked_flag));
				compare_field(idx, "ack_flag", 64'(got.ack_flag), 64'(exp.ack_flag));
				compare_field(idx, "feature_class", 64'(got.feature_class),
					64'(exp.feature_class));
				compare_field(idx, "feature_index", 64'(got.feature_index),
					64'(exp.feature_index));
				compare_field(idx, "function_code", 64'(got.function_code),
					64'(exp.function_code));
				compare_field(idx, "length_out", 64'(got.length_out), 64'(exp.length_out));
				compare_field(idx, "payload_value", got.payload_value, exp.payload_value);
			end
		endtask
	endclass

endpackage

// ===== bench/tb.sv =====
// testbench top for the can receive filter and unpacker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfu_pkg::*;
	import rx_check_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int TARGET_ITEMS = 850;
	localparam int TAIL_CYCLES = 16;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [7:0]  new_module;
	logic [28:0] frame_id;
	logic        is_remote;
	logic [3:0]  payload_length;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic        last_of_run;
	logic [31:0] color;
	logic        event_flag;
	logic [7:0]  source_module;
	logic        linked_flag;
	logic        ack_flag;
	logic [2:0]  feature_class;
	logic [4:0]  feature_index;
	logic [7:0]  function_code;
	logic [3:0]  length_out;
	logic [63:0] payload_value;

	rx_scoreboard sb;
	int  cycles;
	int  burst_left;
	bit  no_gaps;
	bit  hold_request;
	int  hold_left;
	int  mode;
	int  mode_left;
	int  mode_phase;

	can_receive_filter_unpack dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.new_module(new_module),
		.frame_id(frame_id),
		.is_remote(is_remote),
		.payload_length(payload_length),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.last_of_run(last_of_run),
		.color(color),
		.event_flag(event_flag),
		.source_module(source_module),
		.linked_flag(linked_flag),
		.ack_flag(ack_flag),
		.feature_class(feature_class),
		.feature_index(feature_index),
		.function_code(function_code),
		.length_out(length_out),
		.payload_value(payload_value)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d results outstanding",
				cycles, sb.outstanding());
			$display("tb: FAIL");
			$finish;
		end
	end

	// receiver: long hold-off on request, otherwise a stall pattern that changes mode
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (arst_n) begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 80);
			end
			mode_left--;
			mode_phase++;
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= (mode_phase % 3 == 0);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		cfu_result_t r;
		if (arst_n && out_valid && out_ready) begin
			r.kind = kind;
			r.last_of_run = last_of_run;
			r.color = color;
			r.event_flag = event_flag;
			r.source_module = source_module;
			r.linked_flag = linked_flag;
			r.ack_flag = ack_flag;
			r.feature_class = feature_class;
			r.feature_index = feature_index;
			r.function_code = function_code;
			r.length_out = length_out;
			r.payload_value = payload_value;
			sb.check_result(r);
		end
	end

	function automatic cfu_item_t rand_item(logic [1:0] f);
		cfu_item_t it;
		it.func = f;
		it.new_module = 8'($urandom);
		it.frame_id = 29'($urandom);
		it.is_remote = 1'($urandom);
		it.payload_length = 4'($urandom);
		it.data_byte = 8'($urandom);
		return it;
	endfunction

	function automatic logic [28:0] id_from(logic [7:0] src);
		logic [28:0] id;
		id = 29'($urandom);
		id[25:18] = src;
		return id;
	endfunction

	// sender drops in_valid and idles; ends at a rising edge like a transfer does
	task idle_for(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task send_item(cfu_item_t it);
		@(negedge clk);
		in_valid <= 1'b1;
		func <= it.func;
		new_module <= it.new_module;
		frame_id <= it.frame_id;
		is_remote <= it.is_remote;
		payload_length <= it.payload_length;
		data_byte <= it.data_byte;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(it);
		if (!no_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				idle_for($urandom_range(1, 6));
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 10);
			end
		end
	endtask

	task register_module(logic [7:0] m);
		cfu_item_t it;
		it = rand_item(FUNC_REG);
		it.new_module = m;
		send_item(it);
	endtask

	task send_header(logic [28:0] id, logic remote, logic [3:0] len);
		cfu_item_t it;
		it = rand_item(FUNC_HDR);
		it.frame_id = id;
		it.is_remote = remote;
		it.payload_length = len;
		send_item(it);
	endtask

	task send_byte(logic [7:0] b);
		cfu_item_t it;
		it = rand_item(FUNC_BYTE);
		it.data_byte = b;
		send_item(it);
	endtask

	task send_unused();
		send_item(rand_item(FUNC_UNUSED));
	endtask

	task wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// header that passes the filter followed by its payload, sometimes cut short or padded
	task send_message();
		logic [3:0] len;
		int n;
		len = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 8));
		send_header(id_from(sb.pick_match()), 1'b0, len);
		n = (len > PAYLOAD_MAX) ? PAYLOAD_MAX : len;
		if (n > 0 && $urandom_range(0, 9) == 0)
			n = $urandom_range(0, n - 1);
		repeat (n) send_byte(8'($urandom));
		if ($urandom_range(0, 9) == 0)
			send_byte(8'($urandom));
	endtask

	initial begin
		bit filled;
		bit pressed;
		bit drained;
		int pick;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_REG;
		new_module = '0;
		frame_id = '0;
		is_remote = 1'b0;
		payload_length = '0;
		data_byte = '0;
		out_ready = 1'b0;
		cycles = 0;
		burst_left = 4;
		no_gaps = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		mode_phase = 0;
		filled = 1'b0;
		pressed = 1'b0;
		drained = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: source zero passes
		send_header('0, 1'b0, 4'd2);
		send_byte(8'hff);
		send_byte(8'h00);
		register_module(8'h00);
		register_module(8'hff);
		register_module(8'd13);
		// all-ones identifier, zero length: colour and message back to back
		send_header('1, 1'b0, 4'd0);
		// oversized length saturates
		send_header(id_from(8'd13), 1'b0, 4'hf);
		send_byte(8'hff);
		repeat (6) send_byte(8'($urandom));
		send_byte(8'h80);
		send_header(id_from(8'd19), 1'b1, 4'd3);
		send_byte(8'($urandom));
		// header during payload abandons the collection
		send_header(id_from(8'd13), 1'b0, 4'd4);
		send_byte(8'($urandom));
		send_header(id_from(8'd20), 1'b0, 4'd2);
		send_byte(8'($urandom));
		send_unused();
		send_header(id_from(8'd13), 1'b0, 4'd1);
		send_byte(8'($urandom));
		wait_for_results();

		while (sb.useful < TARGET_ITEMS) begin
			if (!filled && sb.useful >= 350) begin
				filled = 1'b1;
				while (!sb.table_full())
					register_module(8'($urandom_range(1, 255)));
				repeat (3) register_module(8'($urandom));
			end
			if (!pressed && sb.useful >= 500) begin
				// receiver holds off while the sender keeps pushing transfers
				pressed = 1'b1;
				hold_request = 1'b1;
				no_gaps = 1'b1;
				repeat (40) send_header(id_from(8'($urandom)), 1'b0,
					4'($urandom_range(0, 8)));
				no_gaps = 1'b0;
			end
			if (!drained && sb.useful >= 700) begin
				drained = 1'b1;
				wait_for_results();
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_message();
			end else if (pick < 80) begin
				send_header(id_from(8'($urandom)), 1'b0, 4'($urandom));
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
			end else if (pick < 88) begin
				if ($urandom_range(0, 1) == 0) begin
					send_header(id_from(sb.pick_match()), 1'b0, 4'd5);
					repeat (2) send_byte(8'($urandom));
				end
				send_header(id_from(8'($urandom)), 1'b1, 4'($urandom));
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
			end else if (pick < 94) begin
				register_module(8'($urandom));
			end else if (pick < 97) begin
				send_unused();
			end else begin
				send_byte(8'($urandom));
			end
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb: %0d items applied: %0d module ids, %0d headers, %0d payload bytes, %0d ignored",
			sb.useful + sb.ignored, sb.n_reg, sb.n_hdr, sb.n_byte, sb.ignored);
		$display("tb: %0d colour and %0d message results compared, table full %0d, %0d mismatches",
			sb.n_colour, sb.n_msg, sb.table_full(), sb.errors);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
